// ----- sv/sdsh_pkg.sv -----
package sdsh_pkg;

  // field widths
  localparam int unsigned DistW   = 16;
  localparam int unsigned CntW    = 32;
  localparam int unsigned SumW    = CntW + DistW;
  localparam int unsigned QuotW   = DistW + 1;
  localparam int unsigned StepW   = 5;
  localparam int unsigned MsW     = 32;
  localparam int unsigned DayW    = 9;
  localparam int unsigned StreakW = 16;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned ThrMsW  = 26;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 168;

  // constants
  localparam logic [ThrW-1:0]    ThrReset    = 16'd30;
  localparam logic [9:0]         MsPerSec    = 10'd1000;
  localparam logic [QuotW-1:0]   RateNum     = 17'd100000;
  localparam logic [StreakW-1:0] WarnStreak  = 16'd3;
  localparam logic [StreakW-1:0] ErrorStreak = 16'd8;
  localparam logic [StepW-1:0]   AvgSteps    = 5'd16;
  localparam logic [StepW-1:0]   RateSteps   = 5'd17;

  // health codes
  localparam logic [1:0] HealthGood  = 2'd0;
  localparam logic [1:0] HealthWarn  = 2'd1;
  localparam logic [1:0] HealthError = 2'd2;

  typedef enum logic [1:0] {
    KIND_READING   = 2'd0,
    KIND_INTRUSION = 2'd1,
    KIND_ALERT     = 2'd2,
    KIND_CLEAR     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_AVG_GO,
    ST_AVG,
    ST_DONE
  } state_e;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [CntW-1:0]   rem;
    logic [QuotW-1:0]  shin;
    logic [StepW-1:0]  steps;
    logic [CntW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QuotW-1:0]  quot;
  } div_rsp_t;

endpackage

// ----- sv/sdsh_div.sv -----
module sdsh_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sdsh_pkg::div_req_t req_i,
  output sdsh_pkg::div_rsp_t rsp_o
);

  logic [sdsh_pkg::CntW-1:0]  r_q, r_d;
  logic [sdsh_pkg::CntW-1:0]  d_q, d_d;
  logic [sdsh_pkg::QuotW-1:0] s_q, s_d;
  logic [sdsh_pkg::QuotW-1:0] q_q, q_d;
  logic [sdsh_pkg::StepW-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [sdsh_pkg::CntW:0]    trial;
  logic [sdsh_pkg::CntW:0]    diff;
  logic                       ge;

  // one restoring step: shift in a dividend bit, compare, subtract
  always_comb begin
    trial = {r_q, s_q[sdsh_pkg::QuotW-1]};
    diff  = trial - {1'b0, d_q};
    ge    = trial >= {1'b0, d_q};
    r_d    = r_q;
    d_d    = d_q;
    s_d    = s_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      r_d    = req_i.rem;
      d_d    = req_i.divisor;
      s_d    = req_i.shin;
      q_d    = '0;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = ge ? diff[sdsh_pkg::CntW-1:0] : trial[sdsh_pkg::CntW-1:0];
      s_d   = {s_q[sdsh_pkg::QuotW-2:0], 1'b0};
      q_d   = {q_q[sdsh_pkg::QuotW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == sdsh_pkg::StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    d_q <= d_d;
    s_q <= s_d;
    q_q <= q_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;

endmodule

// ----- sv/sensor_daily_stats_health.sv -----
// channel   | dir | signals                              | contents
// s_axis    | in  | tvalid/tready, tdata[63:0], tuser[1:0] | event: kind in tuser
// m_axis    | out | tvalid/tready, tdata[167:0]          | daily statistics result
// cfg       | in  | we, wdata[15:0]                      | frozen_threshold_sec
//
// ready stays low while an item is processed; the reading rate is recomputed only on
// a nonzero interval, and the average only while the day holds a valid reading:
// the shared serial divider runs 17 steps for the rate and 16 for the average.
// the statistics update when the item is accepted; ready drops until the result
// moves into the output register, which then waits for m_axis_tready_i.
// reset is asynchronous and active low and restores the threshold to 30 seconds.
module sensor_daily_stats_health (
  input  logic         clk_i,
  input  logic         rst_ni,
  // now_ms[31:0], distance[47:32], reading_valid[48], day_of_year[57:49],
  // time_synced[58], zero fill above
  input  logic [63:0]  s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // min_today[16:0], max_today[33:17], avg_today[50:34], health[52:51],
  // frozen[53], rate_centihz[70:54], intrusions_today[102:71],
  // alerts_today[134:103], valid_run[150:135], invalid_run[166:151], zero[167]
  output logic [167:0] m_axis_tdata_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);

  localparam int unsigned DistW   = sdsh_pkg::DistW;
  localparam int unsigned CntW    = sdsh_pkg::CntW;
  localparam int unsigned SumW    = sdsh_pkg::SumW;
  localparam int unsigned QuotW   = sdsh_pkg::QuotW;
  localparam int unsigned MsW     = sdsh_pkg::MsW;
  localparam int unsigned DayW    = sdsh_pkg::DayW;
  localparam int unsigned StreakW = sdsh_pkg::StreakW;

  sdsh_pkg::state_e state_q, state_d;

  logic [sdsh_pkg::ThrW-1:0] thr_q;
  logic [DistW-1:0]   min_q, min_d, max_q, max_d, held_q, held_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [CntW-1:0]    cnt_q, cnt_d, intr_q, intr_d, alert_q, alert_d;
  logic               day_known_q, day_known_d;
  logic [DayW-1:0]    day_q, day_d;
  logic [StreakW-1:0] good_q, good_d, bad_q, bad_d;
  logic [MsW-1:0]     prev_q, prev_d, hold_ms_q, hold_ms_d;
  logic               held_vld_q, held_vld_d, frozen_q, frozen_d;
  logic [QuotW-1:0]   rate_q, rate_d, avg_q, avg_d;
  logic               out_valid_q, out_valid_d, out_load;
  logic [sdsh_pkg::OutDataW-1:0] out_data_q;

  sdsh_pkg::kind_e in_kind;
  logic [MsW-1:0]   in_now, dt, held_age;
  logic [DistW-1:0] in_dist;
  logic             in_valid, in_sync, s_acc, need_rate;
  logic [DayW-1:0]  in_day;
  logic [sdsh_pkg::ThrMsW-1:0] thr_ms;
  logic [1:0]       health;
  logic [QuotW-1:0] min_out, max_out;

  sdsh_pkg::div_req_t div_req;
  sdsh_pkg::div_rsp_t div_rsp;

  // input unpacking
  assign in_kind  = sdsh_pkg::kind_e'(s_axis_tuser_i);
  assign in_now   = s_axis_tdata_i[31:0];
  assign in_dist  = s_axis_tdata_i[47:32];
  assign in_valid = s_axis_tdata_i[48];
  assign in_day   = s_axis_tdata_i[57:49];
  assign in_sync  = s_axis_tdata_i[58];

  assign s_axis_tready_o = (state_q == sdsh_pkg::ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  assign dt        = in_now - prev_q;
  assign need_rate = (prev_q != '0) && (dt != '0);
  assign held_age  = in_now - hold_ms_q;
  assign thr_ms    = sdsh_pkg::ThrMsW'(thr_q) * sdsh_pkg::ThrMsW'(sdsh_pkg::MsPerSec);

  // statistics update on an accepted item
  always_comb begin
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    intr_d      = intr_q;
    alert_d     = alert_q;
    day_known_d = day_known_q;
    day_d       = day_q;
    good_d      = good_q;
    bad_d       = bad_q;
    prev_d      = prev_q;
    held_vld_d  = held_vld_q;
    held_d      = held_q;
    hold_ms_d   = hold_ms_q;
    frozen_d    = frozen_q;
    if (s_acc) begin
      if (in_kind == sdsh_pkg::KIND_CLEAR) begin
        sum_d       = '0;
        cnt_d       = '0;
        intr_d      = '0;
        alert_d     = '0;
        day_known_d = 1'b0;
        day_d       = '0;
        good_d      = '0;
        bad_d       = '0;
        prev_d      = '0;
        held_vld_d  = 1'b0;
        hold_ms_d   = '0;
        frozen_d    = 1'b0;
      end else begin
        // day rollover
        if (in_sync) begin
          day_known_d = 1'b1;
          day_d       = in_day;
          if (day_known_q && (in_day != day_q)) begin
            sum_d   = '0;
            cnt_d   = '0;
            intr_d  = '0;
            alert_d = '0;
          end
        end
        case (in_kind)
          sdsh_pkg::KIND_READING: begin
            prev_d = in_now;
            if (!in_valid) begin
              if (bad_q != '1) bad_d = bad_q + 1'b1;
              good_d = '0;
            end else begin
              if (good_q != '1) good_d = good_q + 1'b1;
              bad_d = '0;
              if ((cnt_d == '0) || (in_dist < min_q)) min_d = in_dist;
              if ((cnt_d == '0) || (in_dist > max_q)) max_d = in_dist;
              if (cnt_d != '1) begin
                sum_d = sum_d + SumW'(in_dist);
                cnt_d = cnt_d + 1'b1;
              end
              // frozen value tracking
              if (!held_vld_q || (in_dist != held_q)) begin
                held_vld_d = 1'b1;
                held_d     = in_dist;
                hold_ms_d  = in_now;
                frozen_d   = 1'b0;
              end else if (!frozen_q && (held_age >= MsW'(thr_ms))) begin
                frozen_d = 1'b1;
              end
            end
          end
          sdsh_pkg::KIND_INTRUSION: intr_d  = intr_d + 1'b1;
          sdsh_pkg::KIND_ALERT:     alert_d = alert_d + 1'b1;
          default: ;
        endcase
      end
    end
  end

  // sequencer for the shared divider and the output register
  always_comb begin
    state_d         = state_q;
    rate_d          = rate_q;
    avg_d           = avg_q;
    out_load        = 1'b0;
    div_req.start   = 1'b0;
    div_req.rem     = '0;
    div_req.shin    = sdsh_pkg::RateNum;
    div_req.steps   = sdsh_pkg::RateSteps;
    div_req.divisor = dt;
    case (state_q)
      sdsh_pkg::ST_IDLE: begin
        if (s_acc) begin
          if (in_kind == sdsh_pkg::KIND_CLEAR) rate_d = '0;
          if ((in_kind == sdsh_pkg::KIND_READING) && need_rate) begin
            div_req.start = 1'b1;
            state_d       = sdsh_pkg::ST_RATE;
          end else begin
            state_d = sdsh_pkg::ST_AVG_GO;
          end
        end
      end
      sdsh_pkg::ST_RATE: begin
        if (div_rsp.done) begin
          rate_d  = div_rsp.quot;
          state_d = sdsh_pkg::ST_AVG_GO;
        end
      end
      sdsh_pkg::ST_AVG_GO: begin
        if (cnt_q != '0) begin
          div_req.start   = 1'b1;
          div_req.rem     = sum_q[SumW-1 -: CntW];
          div_req.shin    = {sum_q[DistW-1:0], 1'b0};
          div_req.steps   = sdsh_pkg::AvgSteps;
          div_req.divisor = cnt_q;
          state_d         = sdsh_pkg::ST_AVG;
        end else begin
          avg_d   = '1;
          state_d = sdsh_pkg::ST_DONE;
        end
      end
      sdsh_pkg::ST_AVG: begin
        if (div_rsp.done) begin
          avg_d   = div_rsp.quot;
          state_d = sdsh_pkg::ST_DONE;
        end
      end
      sdsh_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = sdsh_pkg::ST_IDLE;
        end
      end
      default: state_d = sdsh_pkg::ST_IDLE;
    endcase
  end

  sdsh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // result fields
  always_comb begin
    if (bad_q >= sdsh_pkg::ErrorStreak)     health = sdsh_pkg::HealthError;
    else if (bad_q >= sdsh_pkg::WarnStreak) health = sdsh_pkg::HealthWarn;
    else                                    health = sdsh_pkg::HealthGood;
    min_out = (cnt_q == '0) ? '1 : {1'b0, min_q};
    max_out = (cnt_q == '0) ? '1 : {1'b0, max_q};
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)             out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdsh_pkg::ST_IDLE;
      thr_q       <= sdsh_pkg::ThrReset;
      cnt_q       <= '0;
      sum_q       <= '0;
      intr_q      <= '0;
      alert_q     <= '0;
      day_known_q <= 1'b0;
      day_q       <= '0;
      good_q      <= '0;
      bad_q       <= '0;
      prev_q      <= '0;
      rate_q      <= '0;
      held_vld_q  <= 1'b0;
      hold_ms_q   <= '0;
      frozen_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      intr_q      <= intr_d;
      alert_q     <= alert_d;
      day_known_q <= day_known_d;
      day_q       <= day_d;
      good_q      <= good_d;
      bad_q       <= bad_d;
      prev_q      <= prev_d;
      rate_q      <= rate_d;
      held_vld_q  <= held_vld_d;
      hold_ms_q   <= hold_ms_d;
      frozen_q    <= frozen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    min_q  <= min_d;
    max_q  <= max_d;
    held_q <= held_d;
    avg_q  <= avg_d;
    if (out_load) begin
      out_data_q <= {1'b0, bad_q, good_q, alert_q, intr_q, rate_q, frozen_q, health,
                     avg_q, max_out, min_out};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // streaks never run at the same time
  a_streaks_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((good_q != '0) && (bad_q != '0)))
    else $error("valid and invalid streaks both nonzero");

  // an empty day carries no sum
  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (sum_q == '0))
    else $error("day sum nonzero with zero count");

  // frozen needs a held value
  a_frozen_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frozen_q |-> held_vld_q)
    else $error("frozen without held value");

  // divider finishes only while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((state_q == sdsh_pkg::ST_RATE) || (state_q == sdsh_pkg::ST_AVG)))
    else $error("divider done outside a wait state");

  // clear-all empties the day and the streaks
  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (in_kind == sdsh_pkg::KIND_CLEAR)) |=>
      ((cnt_q == '0) && (good_q == '0) && (bad_q == '0) && !frozen_q))
    else $error("clear-all left state behind");

endmodule

// ----- test/sensor_daily_stats_health_tb.sv -----
`timescale 1ns / 100ps

// one event as packed on s_axis_tdata_i, lowest field last
typedef struct packed {
  logic [4:0]  pad;
  logic        synced;
  logic [8:0]  day;
  logic        valid;
  logic [15:0] distance;
  logic [31:0] now_ms;
} event_t;

// one statistics result as packed on m_axis_tdata_o
typedef struct packed {
  logic        pad;
  logic [15:0] invalid_run;
  logic [15:0] valid_run;
  logic [31:0] alerts;
  logic [31:0] intrusions;
  logic [16:0] rate;
  logic        frozen;
  logic [1:0]  health;
  logic [16:0] avg;
  logic [16:0] max;
  logic [16:0] min;
} stats_t;

// predicts the daily statistics and checks them against the block
class stats_scoreboard;
  bit [15:0]        thr_sec;
  bit signed [16:0] lo_dist;
  bit signed [16:0] hi_dist;
  bit [47:0]        dist_sum;
  bit [31:0]        dist_cnt;
  bit               day_set;
  bit [8:0]         day_now;
  bit [31:0]        intr_cnt;
  bit [31:0]        alert_cnt;
  bit [15:0]        good_run;
  bit [15:0]        bad_run;
  bit [31:0]        last_read_ms;
  bit [16:0]        rate_chz;
  bit               hold_set;
  bit [15:0]        hold_dist;
  bit [31:0]        hold_ms;
  bit               is_frozen;
  stats_t           expected_stats[$];
  int               errors;

  function new();
    thr_sec = sdsh_pkg::ThrReset;
    errors = 0;
    clear_all();
  endfunction

  function void clear_daily();
    lo_dist = '1;
    hi_dist = '1;
    dist_sum = '0;
    dist_cnt = '0;
    intr_cnt = '0;
    alert_cnt = '0;
  endfunction

  function void clear_all();
    clear_daily();
    day_set = 1'b0;
    day_now = '0;
    good_run = '0;
    bad_run = '0;
    last_read_ms = '0;
    rate_chz = '0;
    hold_set = 1'b0;
    hold_dist = '0;
    hold_ms = '0;
    is_frozen = 1'b0;
  endfunction

  function int pending();
    return expected_stats.size();
  endfunction

  // update the state for one accepted item and queue the stats it should return
  function void note_event(sdsh_pkg::kind_e k, event_t ev);
    stats_t           r;
    bit [31:0]        dt;
    bit signed [16:0] d;
    d = $signed({1'b0, ev.distance});
    if (k == sdsh_pkg::KIND_CLEAR) begin
      clear_all();
    end else begin
      // day rollover only with a synced clock
      if (ev.synced) begin
        if (!day_set) begin
          day_set = 1'b1;
          day_now = ev.day;
        end else if (ev.day != day_now) begin
          day_now = ev.day;
          clear_daily();
        end
      end
      case (k)
        sdsh_pkg::KIND_READING: begin
          // rate from the wrapped interval, zero timestamp means none known
          if (last_read_ms != 0) begin
            dt = ev.now_ms - last_read_ms;
            if (dt != 0) rate_chz = 17'(32'(sdsh_pkg::RateNum) / dt);
          end
          last_read_ms = ev.now_ms;
          if (!ev.valid) begin
            if (bad_run != 16'hFFFF) bad_run++;
            good_run = '0;
          end else begin
            if (good_run != 16'hFFFF) good_run++;
            bad_run = '0;
            if (lo_dist < 0 || d < lo_dist) lo_dist = d;
            if (hi_dist < 0 || d > hi_dist) hi_dist = d;
            if (dist_cnt != 32'hFFFF_FFFF) begin
              dist_sum += 48'(ev.distance);
              dist_cnt++;
            end
            // frozen tracking on valid values only
            if (!hold_set || ev.distance != hold_dist) begin
              hold_set = 1'b1;
              hold_dist = ev.distance;
              hold_ms = ev.now_ms;
              is_frozen = 1'b0;
            end else if (!is_frozen &&
                         (ev.now_ms - hold_ms) >= 32'(thr_sec) * 32'd1000) begin
              is_frozen = 1'b1;
            end
          end
        end
        sdsh_pkg::KIND_INTRUSION: intr_cnt++;
        default: alert_cnt++;
      endcase
    end
    r = '0;
    r.min = lo_dist;
    r.max = hi_dist;
    r.avg = (dist_cnt != 0) ? 17'(dist_sum / 48'(dist_cnt)) : '1;
    if (bad_run >= sdsh_pkg::ErrorStreak) r.health = sdsh_pkg::HealthError;
    else if (bad_run >= sdsh_pkg::WarnStreak) r.health = sdsh_pkg::HealthWarn;
    else r.health = sdsh_pkg::HealthGood;
    r.frozen = is_frozen;
    r.rate = rate_chz;
    r.intrusions = intr_cnt;
    r.alerts = alert_cnt;
    r.valid_run = good_run;
    r.invalid_run = bad_run;
    expected_stats.push_back(r);
  endfunction

  task flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task compare_field(string name, logic [31:0] got, logic [31:0] exp);
    if (got !== exp) flag_mismatch($sformatf("%s got %0h exp %0h", name, got, exp));
  endtask

  // compare one accepted result with the oldest expectation
  task check_result(stats_t got);
    stats_t exp;
    if (expected_stats.size() == 0) begin
      flag_mismatch($sformatf("unexpected result %0h", got));
    end else begin
      exp = expected_stats.pop_front();
      compare_field("min_today", 32'(got.min), 32'(exp.min));
      compare_field("max_today", 32'(got.max), 32'(exp.max));
      compare_field("avg_today", 32'(got.avg), 32'(exp.avg));
      compare_field("health", 32'(got.health), 32'(exp.health));
      compare_field("frozen", 32'(got.frozen), 32'(exp.frozen));
      compare_field("rate_centihz", 32'(got.rate), 32'(exp.rate));
      compare_field("intrusions_today", got.intrusions, exp.intrusions);
      compare_field("alerts_today", got.alerts, exp.alerts);
      compare_field("valid_run", 32'(got.valid_run), 32'(exp.valid_run));
      compare_field("invalid_run", 32'(got.invalid_run), 32'(exp.invalid_run));
      compare_field("pad", 32'(got.pad), 32'(exp.pad));
    end
  endtask
endclass

module sensor_daily_stats_health_tb;

  localparam int unsigned CycleLimit = 700000;
  localparam int unsigned PhaseItems = 300;

  logic         clk_i;
  logic         rst_ni;
  logic [63:0]  s_axis_tdata_i;
  logic [1:0]   s_axis_tuser_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [167:0] m_axis_tdata_o;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic         cfg_we_i;
  logic [15:0]  cfg_wdata_i;

  stats_scoreboard sb;
  int unsigned     cycles;
  int unsigned     items_sent;
  int unsigned     burst_left;
  bit              pressure_done;
  bit [31:0]       t_ms;
  bit [15:0]       last_dist;
  bit [8:0]        cur_day;
  int unsigned     bad_left;

  sensor_daily_stats_health DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("sensor_daily_stats_health_tb: errors");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // receiver stall pattern, with one long hold-off to back up the input
  initial begin : receiver
    int unsigned mode;
    int unsigned n;
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(3);
      for (n = 0; n < 64; n++) begin
        @(negedge clk_i);
        if (!pressure_done && items_sent >= 400) begin
          m_axis_tready_i <= 1'b0;
          repeat (600) @(negedge clk_i);
          pressure_done = 1'b1;
        end
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= 1'($urandom_range(1));
          2: m_axis_tready_i <= ($urandom_range(7) == 0);
          default: m_axis_tready_i <= n[0];
        endcase
      end
    end
  end

  function automatic event_t mk(bit [31:0] now, bit [15:0] dist_in, bit vld, bit [8:0] day,
                                bit sync);
    event_t ev;
    ev = '0;
    ev.now_ms = now;
    ev.distance = dist_in;
    ev.valid = vld;
    ev.day = day;
    ev.synced = sync;
    return ev;
  endfunction

  // offer one item, wait for it to be taken, then pace the sender in bursts
  task automatic offer(sdsh_pkg::kind_e k, event_t ev);
    int unsigned gap;
    s_axis_tuser_i <= k;
    s_axis_tdata_i <= ev;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_event(k, ev);
    items_sent++;
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_threshold(bit [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.thr_sec = v;
  endtask

  // random event with mostly well-formed reading sequences
  task automatic random_event(output sdsh_pkg::kind_e k, output event_t ev);
    int unsigned pick;
    bit [15:0]   dist_val;
    bit          vld;
    bit [8:0]    day;
    bit          sync;
    pick = $urandom_range(99);
    if (pick < 75) k = sdsh_pkg::KIND_READING;
    else if (pick < 85) k = sdsh_pkg::KIND_INTRUSION;
    else if (pick < 96) k = sdsh_pkg::KIND_ALERT;
    else k = sdsh_pkg::KIND_CLEAR;
    // timestamp steps, including repeats, zero, wraps and long holds
    pick = $urandom_range(99);
    if (pick < 55) t_ms += $urandom_range(1, 2000);
    else if (pick < 70) t_ms += $urandom_range(2000, 40000);
    else if (pick < 80) t_ms += $urandom_range(0, 32'(sb.thr_sec) * 1200 + 1000);
    else if (pick < 87) t_ms += 0;
    else if (pick < 91) t_ms = 0;
    else if (pick < 96) t_ms = $urandom;
    else t_ms += 1;
    // distance: repeats of the held value are common
    pick = $urandom_range(99);
    if (pick < 45) dist_val = last_dist;
    else if (pick < 53) dist_val = 16'h0000;
    else if (pick < 61) dist_val = 16'hFFFF;
    else dist_val = 16'($urandom_range(16'hFFFF));
    // invalid runs long enough to reach warning and error health
    if (bad_left == 0 && $urandom_range(29) == 0) bad_left = $urandom_range(1, 12);
    if (bad_left > 0) begin
      vld = 1'b0;
      if (k == sdsh_pkg::KIND_READING) bad_left--;
    end else begin
      vld = ($urandom_range(19) != 0);
    end
    // day index, mostly steady
    pick = $urandom_range(99);
    if (pick < 5) cur_day = 9'($urandom_range(365));
    else if (pick < 8) cur_day = 9'($urandom_range(511));
    sync = ($urandom_range(99) < 85);
    day = sync ? cur_day : 9'($urandom_range(511));
    if (k == sdsh_pkg::KIND_READING && vld) last_dist = dist_val;
    ev = mk(t_ms, dist_val, vld, day, sync);
    ev.distance = (k == sdsh_pkg::KIND_READING) ? dist_val : 16'($urandom);
  endtask

  initial begin : stimulus
    sdsh_pkg::kind_e k;
    event_t          ev;
    bit [15:0]       thr_list[5];
    int unsigned     ph;
    int unsigned     i;
    sb = new();
    cycles = 0;
    items_sent = 0;
    burst_left = 0;
    pressure_done = 1'b0;
    bad_left = 0;
    rst_ni <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tuser_i <= sdsh_pkg::KIND_READING;
    s_axis_tvalid_i <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: first reading at time zero, so the second reading still gives no rate
    offer(sdsh_pkg::KIND_READING, mk(0, 16'h0000, 1'b1, 9'd5, 1'b1));
    offer(sdsh_pkg::KIND_READING, mk(1000, 16'hFFFF, 1'b1, 9'd5, 1'b1));
    // one millisecond interval, then a zero interval
    offer(sdsh_pkg::KIND_READING, mk(1001, 16'hFFFF, 1'b1, 9'd5, 1'b1));
    offer(sdsh_pkg::KIND_READING, mk(1001, 16'hFFFF, 1'b1, 9'd5, 1'b1));
    offer(sdsh_pkg::KIND_INTRUSION, mk(2000, 16'h5555, 1'b0, 9'd5, 1'b1));
    offer(sdsh_pkg::KIND_ALERT, mk(2500, 16'hAAAA, 1'b1, 9'd5, 1'b1));
    // same value held past the default threshold
    offer(sdsh_pkg::KIND_READING, mk(32000, 16'hFFFF, 1'b1, 9'd5, 1'b1));
    // new value clears frozen; unsynced clock skips rollover
    offer(sdsh_pkg::KIND_READING, mk(32500, 16'd1234, 1'b1, 9'd7, 1'b0));
    // invalid streak through warning and error
    for (i = 0; i < 8; i++) begin
      offer(sdsh_pkg::KIND_READING, mk(33000 + i * 100, 16'hFFFF, 1'b0, 9'd5, 1'b1));
    end
    // day change clears daily stats
    offer(sdsh_pkg::KIND_READING, mk(34000, 16'd40000, 1'b1, 9'd6, 1'b1));
    // timestamp wrap
    offer(sdsh_pkg::KIND_READING, mk(32'hFFFF_FFF0, 16'd40000, 1'b1, 9'd6, 1'b1));
    offer(sdsh_pkg::KIND_READING, mk(32'h0000_0010, 16'd40000, 1'b1, 9'd6, 1'b1));
    offer(sdsh_pkg::KIND_READING, mk(32'h8000_0000, 16'd300, 1'b1, 9'h1FF, 1'b1));
    // clear all, then events on the cleared state
    offer(sdsh_pkg::KIND_CLEAR, event_t'({$urandom, $urandom}));
    offer(sdsh_pkg::KIND_INTRUSION, mk(5, 16'h0000, 1'b0, 9'd100, 1'b0));
    offer(sdsh_pkg::KIND_READING, mk(0, 16'd77, 1'b1, 9'd100, 1'b1));

    // random phases, each under its own frozen threshold
    t_ms = 32'd100;
    last_dist = 16'd77;
    cur_day = 9'd100;
    thr_list[0] = 16'd0;
    thr_list[1] = 16'd1;
    thr_list[2] = 16'hFFFF;
    thr_list[3] = 16'd3;
    thr_list[4] = 16'($urandom_range(1, 16'hFFFF));
    for (ph = 0; ph < 5; ph++) begin
      s_axis_tvalid_i <= 1'b0;
      wait_drained();
      write_threshold(thr_list[ph]);
      for (i = 0; i < PhaseItems; i++) begin
        random_event(k, ev);
        offer(k, ev);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sensor_daily_stats_health_tb: clean");
    end else begin
      $display("sensor_daily_stats_health_tb: errors");
    end
    $finish;
  end

endmodule
